// ===== hdl/assert_macros.svh =====
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// check a property on the rising edge, masked while reset is held
`define FM_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion label failed");
// check a property on the rising edge, also while reset is held
`define FM_ASSERT_RST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion label failed");
`else
`define FM_ASSERT(label, clk, rst_n, prop)
`define FM_ASSERT_RST(label, clk, prop)
`endif
`endif

// ===== hdl/fmpd_pkg.sv =====
// constants, arctangent table and helpers for the fm phase difference discriminator
package fmpd_pkg;

    localparam int PHASE_BITS_DEF   = 16;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int MAX_STEPS        = 24;
    localparam int STEP_IDX_W       = 5;
    localparam int SAMPLE_W         = 9;
    localparam int GUARD_BITS       = 24;
    // sample plus sign of its negation plus guard bits plus room for cordic gain
    localparam int DP_W             = SAMPLE_W + 1 + GUARD_BITS + 2;
    localparam int OUT_W            = 16;
    localparam int S_TDATA_W        = 24;
    localparam int M_TDATA_W        = 16;

    // atan(2^-k) with one turn = 2^32
    localparam logic [31:0] ATAN_TURN32 [MAX_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    // table entry rounded to pb bits per turn
    function automatic logic [31:0] angle_step(input logic [STEP_IDX_W-1:0] k,
                                               input int pb);
        logic [32:0] t;
        t = {1'b0, ATAN_TURN32[k]} + (33'd1 << (32 - pb - 1));
        return 32'(t >> (32 - pb));
    endfunction

endpackage

// ===== hdl/fm_phase_difference_discriminator_top.sv =====
// top level of the fm phase difference discriminator, bit-serial cordic datapath
//
// usage:
// - input channel s_*: one complex sample per transfer, i and q signed 9 bit,
//   s_tuser high marks the first sample of a block (its result is zero)
// - result channel m_*: one signed 16 bit phase step per input transfer,
//   units of pi/32768, wrapped into [-pi, pi)
// - the cordic vectoring runs bit-serially: x, y and the angle pass through
//   shift registers one bit per cycle, one micro-rotation per pass over the
//   DP_W = 36 bit word
// - s_tready is high only while the datapath is free, so one item is in work
//   at a time
// - the result sits in an output register: a new sample is taken while the
//   previous result still waits for m_tready; if the receiver stalls longer
//   than a full item the finished item waits in its last state and s_tready
//   stays low
// - reset (aresetn low, synchronous) empties the output register, returns the
//   sequencer to idle and clears the stored previous phase
`include "assert_macros.svh"

module fm_phase_difference_discriminator_top #(
    parameter int PHASE_BITS   = fmpd_pkg::PHASE_BITS_DEF,
    parameter int CORDIC_STEPS = fmpd_pkg::CORDIC_STEPS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // [8:0] i_sample, [17:9] q_sample, [23:18] zero
    input  logic [fmpd_pkg::S_TDATA_W-1:0] s_tdata,
    // [0] block_start
    input  logic                           s_tuser,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [15:0] phase_step
    output logic [fmpd_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready
);
    import fmpd_pkg::*;

    localparam int W      = DP_W;
    localparam int IW     = $clog2(W);
    localparam int NSTEPS = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;
    localparam int SW     = $clog2(NSTEPS);
    localparam int PB     = PHASE_BITS;
    localparam int PBW    = $clog2(PB);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROTATE,
        ST_FINISH
    } state_t;

    state_t            state_reg, state_next;
    logic [W-1:0]      x_reg, x_next;
    logic [W-1:0]      y_reg, y_next;
    logic [PB-1:0]     acc_reg, acc_next;
    logic              x_sgn_reg, x_sgn_next;
    logic              y_sgn_reg, y_sgn_next;
    logic              cx_reg, cx_next;
    logic              cy_reg, cy_next;
    logic              ca_reg, ca_next;
    logic [IW-1:0]     bit_cnt_reg, bit_cnt_next;
    logic [SW-1:0]     step_cnt_reg, step_cnt_next;
    logic              zero_reg, zero_next;
    logic              start_reg, start_next;
    logic [OUT_W-1:0]  prev_reg, prev_next;
    logic [OUT_W-1:0]  m_tdata_reg, m_tdata_next;
    logic              m_tvalid_reg, m_tvalid_next;

    // input fields
    logic signed [SAMPLE_W-1:0] i_sample;
    logic signed [SAMPLE_W-1:0] q_sample;
    logic                       block_start;
    assign i_sample    = s_tdata[SAMPLE_W-1:0];
    assign q_sample    = s_tdata[2*SAMPLE_W-1:SAMPLE_W];
    assign block_start = s_tuser;

    // pre-rotation into the right half plane
    logic                i_neg;
    logic [SAMPLE_W:0]   i_ext, q_ext, i_abs, q_rot;
    logic [W-1:0]        x_load, y_load;
    assign i_neg  = i_sample[SAMPLE_W-1];
    assign i_ext  = {i_sample[SAMPLE_W-1], i_sample};
    assign q_ext  = {q_sample[SAMPLE_W-1], q_sample};
    assign i_abs  = i_neg ? (~i_ext + 1'b1) : i_ext;
    assign q_rot  = i_neg ? (~q_ext + 1'b1) : q_ext;
    assign x_load = {{(W-SAMPLE_W-1-GUARD_BITS){i_abs[SAMPLE_W]}}, i_abs, {GUARD_BITS{1'b0}}};
    assign y_load = {{(W-SAMPLE_W-1-GUARD_BITS){q_rot[SAMPLE_W]}}, q_rot, {GUARD_BITS{1'b0}}};

    // serial micro-rotation: bit j of this pass, shift k = step count
    logic           dir_pos;    // y >= 0 at the start of the pass
    logic           first_bit;
    logic           last_bit;
    logic           last_step;
    logic           tap_ok;
    logic           xs_bit, ys_bit;
    logic           bx, by, cx_in, cy_in, sx, sy, cx_out, cy_out;
    logic [PB-1:0]  angle;
    logic           a_on, a_bit, ba, ca_in, sa, ca_out;

    assign dir_pos   = ~y_sgn_reg;
    assign first_bit = (bit_cnt_reg == '0);
    assign last_bit  = (bit_cnt_reg == IW'(W - 1));
    assign last_step = (step_cnt_reg == SW'(NSTEPS - 1));

    // after j shifts, original bit j+k sits at position k; above the top it is the sign
    assign tap_ok = ({1'b0, bit_cnt_reg} + (IW+1)'(step_cnt_reg)) < (IW+1)'(W);
    assign xs_bit = tap_ok ? x_reg[IW'(step_cnt_reg)] : x_sgn_reg;
    assign ys_bit = tap_ok ? y_reg[IW'(step_cnt_reg)] : y_sgn_reg;

    // x += ys or x -= ys, subtraction as add of the complement with carry in
    assign bx     = dir_pos ? ys_bit : ~ys_bit;
    assign cx_in  = first_bit ? ~dir_pos : cx_reg;
    assign sx     = x_reg[0] ^ bx ^ cx_in;
    assign cx_out = (x_reg[0] & bx) | (x_reg[0] & cx_in) | (bx & cx_in);

    // y -= xs or y += xs
    assign by     = dir_pos ? ~xs_bit : xs_bit;
    assign cy_in  = first_bit ? dir_pos : cy_reg;
    assign sy     = y_reg[0] ^ by ^ cy_in;
    assign cy_out = (y_reg[0] & by) | (y_reg[0] & cy_in) | (by & cy_in);

    // angle accumulator runs over the low PB bits of each pass, wraps mod 2^PB
    assign angle  = PB'(angle_step(STEP_IDX_W'(step_cnt_reg), PB));
    assign a_on   = ({1'b0, bit_cnt_reg} < (IW+1)'(PB));
    assign a_bit  = angle[bit_cnt_reg[PBW-1:0]];
    assign ba     = dir_pos ? a_bit : ~a_bit;
    assign ca_in  = first_bit ? ~dir_pos : ca_reg;
    assign sa     = acc_reg[0] ^ ba ^ ca_in;
    assign ca_out = (acc_reg[0] & ba) | (acc_reg[0] & ca_in) | (ba & ca_in);

    // angle to 16 bits per turn
    logic [OUT_W-1:0] phase16;
    logic [OUT_W-1:0] phase_out;
    generate
        if (PB > OUT_W) begin : g_round
            localparam int SH = PB - OUT_W;
            logic [PB:0] rounded;
            assign rounded = {1'b0, acc_reg} + ((PB+1)'(1) << (SH - 1));
            assign phase16 = rounded[SH +: OUT_W];
        end else if (PB == OUT_W) begin : g_same
            assign phase16 = acc_reg;
        end else begin : g_widen
            assign phase16 = {acc_reg, {(OUT_W-PB){1'b0}}};
        end
    endgenerate
    assign phase_out = zero_reg ? '0 : phase16;

    logic out_free;
    assign out_free = ~m_tvalid_reg | m_tready;

    always_comb begin
        state_next    = state_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        acc_next      = acc_reg;
        x_sgn_next    = x_sgn_reg;
        y_sgn_next    = y_sgn_reg;
        cx_next       = cx_reg;
        cy_next       = cy_reg;
        ca_next       = ca_reg;
        bit_cnt_next  = bit_cnt_reg;
        step_cnt_next = step_cnt_reg;
        zero_next     = zero_reg;
        start_next    = start_reg;
        prev_next     = prev_reg;
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg & ~m_tready;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    x_next        = x_load;
                    y_next        = y_load;
                    x_sgn_next    = x_load[W-1];
                    y_sgn_next    = y_load[W-1];
                    acc_next      = i_neg ? (PB'(1) << (PB - 1)) : '0;
                    zero_next     = (i_sample == '0) && (q_sample == '0);
                    start_next    = block_start;
                    bit_cnt_next  = '0;
                    step_cnt_next = '0;
                    state_next    = ST_ROTATE;
                end
            end
            ST_ROTATE: begin
                x_next  = {sx, x_reg[W-1:1]};
                y_next  = {sy, y_reg[W-1:1]};
                cx_next = cx_out;
                cy_next = cy_out;
                if (a_on) begin
                    acc_next = {sa, acc_reg[PB-1:1]};
                    ca_next  = ca_out;
                end
                if (last_bit) begin
                    x_sgn_next    = sx;
                    y_sgn_next    = sy;
                    bit_cnt_next  = '0;
                    step_cnt_next = step_cnt_reg + 1'b1;
                    if (last_step) begin
                        state_next = ST_FINISH;
                    end
                end else begin
                    bit_cnt_next = bit_cnt_reg + 1'b1;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_tdata_next  = start_reg ? '0 : (phase_out - prev_reg);
                    m_tvalid_next = 1'b1;
                    prev_next     = phase_out;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        x_reg        <= x_next;
        y_reg        <= y_next;
        acc_reg      <= acc_next;
        x_sgn_reg    <= x_sgn_next;
        y_sgn_reg    <= y_sgn_next;
        cx_reg       <= cx_next;
        cy_reg       <= cy_next;
        ca_reg       <= ca_next;
        bit_cnt_reg  <= bit_cnt_next;
        step_cnt_reg <= step_cnt_next;
        zero_reg     <= zero_next;
        start_reg    <= start_next;
        m_tdata_reg  <= m_tdata_next;
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            prev_reg     <= '0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            prev_reg     <= prev_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tdata  = m_tdata_reg;
    assign m_tvalid = m_tvalid_reg;

    // reset leaves the sequencer idle with an empty output register
    `FM_ASSERT_RST(a_reset_idle, aclk, !aresetn |=> (state_reg == ST_IDLE) && !m_tvalid_reg)
    // an accepted sample starts the first pass of the first micro-rotation
    `FM_ASSERT(a_accept_starts, aclk, aresetn, (s_tvalid && s_tready) |=> (state_reg == ST_ROTATE) && (bit_cnt_reg == '0) && (step_cnt_reg == '0))
    // a result only appears when an item leaves its last state
    `FM_ASSERT(a_valid_from_finish, aclk, aresetn, $rose(m_tvalid_reg) |-> $past(state_reg) == ST_FINISH)
    // the bit counter never runs past the datapath word while rotating
    `FM_ASSERT(a_bit_cnt_range, aclk, aresetn, (state_reg == ST_ROTATE) |-> bit_cnt_reg <= IW'(W - 1))
    // the first sample of a block gives a zero step
    `FM_ASSERT(a_block_start_zero, aclk, aresetn, (state_reg == ST_FINISH && out_free && start_reg) |=> m_tdata_reg == '0)

endmodule

// ===== tb/testbench.sv =====
// self-checking stream testbench for the fm phase difference discriminator
`timescale 1ns / 1ps

module testbench;

    localparam int PHASE_BITS   = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int GUARD_SHIFT  = 24;
    localparam int ROT_MAX      = 24;
    localparam int LONG_HOLD    = 3000;
    localparam int ITEM_CYCLES  = CORDIC_STEPS * 36 + 2;
    localparam int N_ITEMS      = 650;

    // arctangent of 2^-k, one turn = 2^32
    localparam logic [31:0] ATAN_TURN [ROT_MAX] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    typedef struct {
        logic signed [8:0] i_val;
        logic signed [8:0] q_val;
        logic              first;
    } iq_sample_t;

    logic                           aclk     = 1'b0;
    logic                           aresetn  = 1'b0;
    logic [fmpd_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic                           s_tuser  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [fmpd_pkg::M_TDATA_W-1:0] m_tdata;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;

    iq_sample_t  pending_samples[$];
    logic [15:0] expected_steps[$];
    logic [15:0] last_phase = '0;
    iq_sample_t  cur_tx;

    int  tx_gap = 0;
    bit  tx_calm = 1'b0;
    int  rx_wait = 0;
    int  rx_next;
    bit  rx_calm = 1'b0;
    int  hold_left = 0;
    int  holds_done = 0;
    int  samples_accepted = 0;
    int  steps_checked = 0;
    int  mismatches = 0;
    logic [15:0] want;

    fm_phase_difference_discriminator_top #(
        .PHASE_BITS  (PHASE_BITS),
        .CORDIC_STEPS(CORDIC_STEPS)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tdata (m_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready)
    );

    always #5 aclk = ~aclk;

    // binary angle of one sample, cordic vectoring, 16 bits per turn
    function automatic logic [15:0] sample_phase(input logic signed [8:0] i_s,
                                                 input logic signed [8:0] q_s);
        longint x, y, xs, ys;
        longint unsigned acc, a_k, mask;
        int n_rot;
        mask = (64'd1 << PHASE_BITS) - 1;
        if (i_s == 0 && q_s == 0)
            return '0;
        x = longint'(i_s) <<< GUARD_SHIFT;
        y = longint'(q_s) <<< GUARD_SHIFT;
        acc = 0;
        // left half plane: rotate by pi first
        if (x < 0) begin
            x = -x;
            y = -y;
            acc = 64'd1 << (PHASE_BITS - 1);
        end
        n_rot = (CORDIC_STEPS > ROT_MAX) ? ROT_MAX : CORDIC_STEPS;
        for (int k = 0; k < n_rot; k++) begin
            xs = x >>> k;
            ys = y >>> k;
            a_k = ({32'd0, ATAN_TURN[k]} + (64'd1 << (31 - PHASE_BITS))) >> (32 - PHASE_BITS);
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                acc = (acc + a_k) & mask;
            end else begin
                x = x - ys;
                y = y + xs;
                acc = (acc - a_k) & mask;
            end
        end
        if (PHASE_BITS > 16)
            return 16'((acc + (64'd1 << (PHASE_BITS - 17))) >> (PHASE_BITS - 16));
        return 16'(acc << (16 - PHASE_BITS));
    endfunction

    // phase difference against the stored phase, wraps modulo one turn
    function automatic logic [15:0] next_phase_step(input logic signed [8:0] i_s,
                                                    input logic signed [8:0] q_s,
                                                    input logic first);
        logic [15:0] ph, step;
        ph = sample_phase(i_s, q_s);
        step = first ? 16'd0 : ph - last_phase;
        last_phase = ph;
        return step;
    endfunction

    function automatic void add_sample(input int vi, input int vq, input bit first);
        pending_samples.push_back('{i_val: 9'(vi), q_val: 9'(vq), first: first});
    endfunction

    // input side: one sample per transfer, random gaps between items
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_gap   <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_steps.push_back(next_phase_step(s_tdata[8:0], s_tdata[17:9], s_tuser));
                samples_accepted <= samples_accepted + 1;
            end
            if (s_tvalid && !s_tready) begin
                // transfer still offered, hold the bus
            end else if (tx_gap > 0) begin
                tx_gap   <= tx_gap - 1;
                s_tvalid <= 1'b0;
            end else if (pending_samples.size() != 0) begin
                cur_tx = pending_samples.pop_front();
                s_tdata  <= fmpd_pkg::S_TDATA_W'({cur_tx.q_val, cur_tx.i_val});
                s_tuser  <= cur_tx.first;
                s_tvalid <= 1'b1;
                if ($urandom_range(0, 31) == 0)
                    tx_calm = !tx_calm;
                tx_gap <= tx_calm ? 0 : $urandom_range(0, 5);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // long receiver stall so the output register fills and s_tready drops
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left  <= 0;
            holds_done <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (holds_done < 2 && samples_accepted >= 120 + 360 * holds_done) begin
            hold_left  <= LONG_HOLD;
            holds_done <= holds_done + 1;
        end
    end

    // result side: compare each transfer with the oldest predicted step
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait  <= 0;
        end else begin
            rx_next = rx_wait;
            if (m_tvalid && m_tready) begin
                if (expected_steps.size() == 0) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("unexpected phase step %0d, none pending", $signed(m_tdata));
                end else begin
                    want = expected_steps.pop_front();
                    if (m_tdata !== want) begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10)
                            $display("phase step %0d: expected %0d, got %0d",
                                     steps_checked, $signed(want), $signed(m_tdata));
                    end
                    steps_checked = steps_checked + 1;
                end
                if ($urandom_range(0, 31) == 0)
                    rx_calm = !rx_calm;
                rx_next = rx_calm ? 0 : $urandom_range(0, 5);
            end else if (m_tvalid && rx_next > 0) begin
                rx_next = rx_next - 1;
            end
            rx_wait  <= rx_next;
            m_tready <= (rx_next == 0) && (hold_left == 0);
        end
    end

    initial begin
        int mode, vi, vq, prev_i, prev_q;
        bit first;
        // directed: axes, diagonals, zero sample, exact pi steps, block starts
        add_sample(255, 0, 1'b1);
        add_sample(-255, 0, 1'b0);
        add_sample(0, 255, 1'b0);
        add_sample(0, -255, 1'b0);
        add_sample(0, 0, 1'b0);
        add_sample(255, 255, 1'b0);
        add_sample(-255, -255, 1'b0);
        add_sample(-255, 255, 1'b0);
        add_sample(255, -255, 1'b0);
        add_sample(100, 37, 1'b0);
        add_sample(-100, -37, 1'b0);
        add_sample(0, 0, 1'b1);
        add_sample(-1, 0, 1'b0);
        add_sample(1, 0, 1'b0);
        add_sample(-1, -1, 1'b0);
        add_sample(1, 1, 1'b0);
        add_sample(-255, 1, 1'b1);
        add_sample(-255, -1, 1'b0);
        add_sample(3, -255, 1'b0);
        add_sample(-3, 255, 1'b0);
        add_sample(0, 0, 1'b0);
        add_sample(0, 0, 1'b0);
        prev_i = 0;
        prev_q = 0;
        while (pending_samples.size() < N_ITEMS) begin
            mode  = $urandom_range(0, 9);
            first = ($urandom_range(0, 19) == 0);
            if (mode <= 5) begin
                vi = int'($urandom_range(0, 510)) - 255;
                vq = int'($urandom_range(0, 510)) - 255;
            end else if (mode <= 7) begin
                vi = int'($urandom_range(0, 8)) - 4;
                vq = int'($urandom_range(0, 8)) - 4;
            end else if (mode == 8) begin
                vi = (int'($urandom_range(0, 2)) - 1) * 255;
                vq = (int'($urandom_range(0, 2)) - 1) * 255;
            end else begin
                // opposite point: a step of exactly pi
                vi = -prev_i;
                vq = -prev_q;
            end
            add_sample(vi, vq, first);
            prev_i = vi;
            prev_q = vq;
        end

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_samples.size() != 0 || s_tvalid || expected_steps.size() != 0)
            @(posedge aclk);
        repeat (2 * ITEM_CYCLES) @(posedge aclk);
        if (mismatches == 0 && expected_steps.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // timeout guard
    initial begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
